// ===== hw/rtl/rqd_pkg.sv =====
package rqd_pkg;

   // Default ring depth
   localparam int QUEUE_DEPTH_DFLT = 16;

   // Payload widths
   localparam int ACTION_W = 2;
   localparam int PID_W    = 8;
   localparam int TIME_W   = 16;
   localparam int COUNT_W  = 5;
   localparam int SUM_W    = 20;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_ENQ   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQ   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STEAL = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

   // One ring slot
   typedef struct packed {
      logic [PID_W-1:0]  proc_id;
      logic [TIME_W-1:0] time_left;
   } rqd_entry_type;

   // Slot memory strobes and write data
   typedef struct packed {
      logic          wr_en;
      logic          rd_en;
      rqd_entry_type wr_data;
   } rqd_ram_cmd_type;

endpackage

// ===== hw/rtl/rqd_req_if.sv =====
interface rqd_req_if;
   import rqd_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PID_W-1:0]    proc_id;
   logic [TIME_W-1:0]   time_left;

   modport source (output valid, action, proc_id, time_left, input ready);
   modport sink   (input valid, action, proc_id, time_left, output ready);

endinterface

// ===== hw/rtl/rqd_rsp_if.sv =====
interface rqd_rsp_if;
   import rqd_pkg::*;

   logic               valid;
   logic               ready;
   logic               found;
   logic [PID_W-1:0]   out_proc_id;
   logic [TIME_W-1:0]  out_time_left;
   logic               overflow;
   logic [COUNT_W-1:0] entry_count;
   logic [SUM_W-1:0]   time_total;

   modport source (output valid, found, out_proc_id, out_time_left, overflow,
                   entry_count, time_total, input ready);
   modport sink   (input valid, found, out_proc_id, out_time_left, overflow,
                   entry_count, time_total, output ready);

endinterface

// ===== hw/rtl/rqd_slot_ram.sv =====
module rqd_slot_ram #(
   parameter int DEPTH = rqd_pkg::QUEUE_DEPTH_DFLT,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  rqd_pkg::rqd_ram_cmd_type cmd,
   input  logic [PTR_W-1:0]        wr_addr,
   input  logic [PTR_W-1:0]        rd_addr,
   output rqd_pkg::rqd_entry_type  rd_data
);
   import rqd_pkg::*;

   rqd_entry_type mem [DEPTH];
   rqd_entry_type rd_data_ff;

   // Single write port, single registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rqd_ctrl.sv =====
module rqd_ctrl #(
   parameter int DEPTH = rqd_pkg::QUEUE_DEPTH_DFLT,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rqd_pkg::ACTION_W-1:0]  req_action,
   input  logic [rqd_pkg::PID_W-1:0]     req_proc_id,
   input  logic [rqd_pkg::TIME_W-1:0]    req_time_left,
   // response side
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [rqd_pkg::PID_W-1:0]     rsp_proc_id,
   output logic [rqd_pkg::TIME_W-1:0]    rsp_time_left,
   output logic                          rsp_overflow,
   output logic [rqd_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic [rqd_pkg::SUM_W-1:0]     rsp_time_total,
   // slot memory
   output rqd_pkg::rqd_ram_cmd_type      ram_cmd,
   output logic [PTR_W-1:0]              ram_wr_addr,
   output logic [PTR_W-1:0]              ram_rd_addr,
   input  rqd_pkg::rqd_entry_type        ram_rd_data
);
   import rqd_pkg::*;

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic              state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff, found_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [TIME_W-1:0]  tl_ff, tl_in;
   logic               ovf_ff, ovf_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]   tot_ff, tot_in;

   logic              accept;
   logic              is_enq;
   logic              is_rem;
   logic              full;
   logic              empty;
   logic [PTR_W-1:0]  head_next;
   logic [PTR_W-1:0]  tail_next;
   logic [PTR_W-1:0]  tail_prev;

   // Hold requests while a removal waits on the memory or the result is stuck
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_enq    = (req_action == ACT_ENQ);
   assign is_rem    = (req_action == ACT_DEQ) || (req_action == ACT_STEAL);
   assign full      = (occ_ff == OCC_FULL);
   assign empty     = (occ_ff == '0);

   assign head_next = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? PTR_LAST : tail_ff - 1'b1;

   assign ram_wr_addr = tail_ff;
   assign ram_rd_addr = (req_action == ACT_STEAL) ? tail_prev : head_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      pid_in       = pid_ff;
      tl_in        = tl_ff;
      ovf_in       = ovf_ff;
      tot_in       = tot_ff;
      ram_cmd      = '0;

      ram_cmd.wr_data.proc_id   = req_proc_id;
      ram_cmd.wr_data.time_left = req_time_left;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               found_in = 1'b0;
               pid_in   = '0;
               tl_in    = '0;
               ovf_in   = 1'b0;
               if (is_enq) begin
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     ram_cmd.wr_en = 1'b1;
                     tail_in       = tail_next;
                     occ_in        = occ_ff + 1'b1;
                     sum_in        = sum_ff + SUM_W'(req_time_left);
                  end
                  rsp_valid_in = 1'b1;
               end else if (is_rem && !empty) begin
                  // Advance pointers now, settle the sum once the slot is read
                  ram_cmd.rd_en = 1'b1;
                  occ_in        = occ_ff - 1'b1;
                  if (req_action == ACT_STEAL) begin
                     tail_in = tail_prev;
                  end else begin
                     head_in = head_next;
                  end
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
               tot_in = sum_in;
            end
         end
         S_READ: begin
            found_in     = 1'b1;
            pid_in       = ram_rd_data.proc_id;
            tl_in        = ram_rd_data.time_left;
            ovf_in       = 1'b0;
            sum_in       = sum_ff - SUM_W'(ram_rd_data.time_left);
            tot_in       = sum_in;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Count field follows the port width, wrapping for deep rings
      cnt_in = COUNT_W'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      pid_ff   <= pid_in;
      tl_ff    <= tl_in;
      ovf_ff   <= ovf_in;
      cnt_ff   <= cnt_in;
      tot_ff   <= tot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_proc_id     = pid_ff;
   assign rsp_time_left   = tl_ff;
   assign rsp_overflow    = ovf_ff;
   assign rsp_entry_count = cnt_ff;
   assign rsp_time_total  = tot_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("occupancy exceeds ring depth");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("result register busy while a removal completes");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_cmd.wr_en && ram_cmd.rd_en))
      else $error("slot memory read and written in one cycle");

   a_remove_reads: assert property (@(posedge clock) disable iff (reset)
      (accept && is_rem && !empty) |=> (state_ff == S_READ) && !rsp_valid_ff)
      else $error("removal did not wait for slot data");

   a_read_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> rsp_valid_ff && rsp_found && (state_ff == S_IDLE))
      else $error("removal produced no result");

endmodule

// ===== hw/rtl/ready_queue_deque_with_time_sum.sv =====
// Bounded ready queue of process ids, held as a ring in a synchronous slot
// memory, with a running total of the remaining times captured at enqueue.
// Every request (enqueue at tail, dequeue from head, steal from tail, query)
// returns exactly one response carrying the entry count and the total after
// the request. Removal from an empty queue returns found = 0; an enqueue into
// a full queue is dropped and flagged with overflow = 1. Enqueue, query and
// any request that finds nothing to remove go straight to the response
// register, so they can follow each other every cycle as long as responses
// are taken. A dequeue or steal that removes an entry first reads its slot
// from the registered slot memory, and the next request is held until the
// read data has been turned into the response. The response sits in an
// output register, so the next request is taken in the same cycle that the
// previous response leaves. Slot contents are not cleared at reset; only
// occupied slots are ever read, so no clearing pass is needed and the block
// accepts requests right after reset. QUEUE_DEPTH may be any value from 2
// up; past depth 16 the time total can wrap, past 31 the entry count too.
module ready_queue_deque_with_time_sum #(
   parameter int QUEUE_DEPTH = rqd_pkg::QUEUE_DEPTH_DFLT
) (
   input logic       clock,
   input logic       reset,
   rqd_req_if.sink   req_chan,
   rqd_rsp_if.source rsp_chan
);
   import rqd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   rqd_ram_cmd_type  ram_cmd;
   logic [PTR_W-1:0] ram_wr_addr;
   logic [PTR_W-1:0] ram_rd_addr;
   rqd_entry_type    ram_rd_data;

   // Pointers, counters, sequencing and the response register
   rqd_ctrl #(
      .DEPTH (QUEUE_DEPTH),
      .PTR_W (PTR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_action      (req_chan.action),
      .req_proc_id     (req_chan.proc_id),
      .req_time_left   (req_chan.time_left),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_found       (rsp_chan.found),
      .rsp_proc_id     (rsp_chan.out_proc_id),
      .rsp_time_left   (rsp_chan.out_time_left),
      .rsp_overflow    (rsp_chan.overflow),
      .rsp_entry_count (rsp_chan.entry_count),
      .rsp_time_total  (rsp_chan.time_total),
      .ram_cmd         (ram_cmd),
      .ram_wr_addr     (ram_wr_addr),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   // Ring storage: one write and one registered read per cycle
   rqd_slot_ram #(
      .DEPTH (QUEUE_DEPTH),
      .PTR_W (PTR_W)
   ) u_slot_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .wr_addr (ram_wr_addr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== verif/rqd_tb_pkg.sv =====
`timescale 1ns / 100ps

package rqd_tb_pkg;
   import rqd_pkg::*;

   localparam int RING_DEPTH = QUEUE_DEPTH_DFLT;
   localparam int SHOWN_MISMATCHES = 10;

   // One response as it leaves the block, in port order
   typedef struct packed {
      logic               found;
      logic [PID_W-1:0]   proc_id;
      logic [TIME_W-1:0]  time_left;
      logic               overflow;
      logic [COUNT_W-1:0] entry_count;
      logic [SUM_W-1:0]   time_total;
   } rqd_rsp_type;

   // Shadow copy of the ready queue plus the responses it still owes
   class ready_queue_shadow;
      rqd_entry_type    slots [RING_DEPTH];
      int unsigned      head;
      int unsigned      tail;
      int unsigned      held;
      logic [SUM_W-1:0] total;
      rqd_rsp_type      owed [$];
      int unsigned      mismatches;

      function new();
         head       = 0;
         tail       = 0;
         held       = 0;
         total      = '0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return owed.size();
      endfunction

      // Advance the shadow queue by one accepted request; queue its response
      function void note_request(logic [ACTION_W-1:0] action, logic [PID_W-1:0] pid,
                                 logic [TIME_W-1:0] tl);
         rqd_rsp_type   rsp;
         rqd_entry_type taken;
         rsp = '0;
         case (action)
            ACT_ENQ: begin
               if (held >= RING_DEPTH) begin
                  rsp.overflow = 1'b1;
               end else begin
                  slots[tail].proc_id   = pid;
                  slots[tail].time_left = tl;
                  tail  = (tail + 1 == RING_DEPTH) ? 0 : tail + 1;
                  held  = held + 1;
                  total = total + SUM_W'(tl);
               end
            end
            ACT_DEQ, ACT_STEAL: begin
               if (held != 0) begin
                  if (action == ACT_DEQ) begin
                     taken = slots[head];
                     head  = (head + 1 == RING_DEPTH) ? 0 : head + 1;
                  end else begin
                     tail  = (tail == 0) ? RING_DEPTH - 1 : tail - 1;
                     taken = slots[tail];
                  end
                  rsp.found     = 1'b1;
                  rsp.proc_id   = taken.proc_id;
                  rsp.time_left = taken.time_left;
                  held  = held - 1;
                  total = total - SUM_W'(taken.time_left);
               end
            end
            default: ;
         endcase
         rsp.entry_count = COUNT_W'(held);
         rsp.time_total  = total;
         owed.push_back(rsp);
      endfunction

      function void report(string what, rqd_rsp_type want, rqd_rsp_type got);
         mismatches++;
         if (mismatches <= SHOWN_MISMATCHES) begin
            $display("%0t %s", $time, what);
            $display("   want found=%0d pid=%0d time=%0d ovf=%0d count=%0d total=%0d",
                     want.found, want.proc_id, want.time_left, want.overflow,
                     want.entry_count, want.time_total);
            $display("   got  found=%0d pid=%0d time=%0d ovf=%0d count=%0d total=%0d",
                     got.found, got.proc_id, got.time_left, got.overflow,
                     got.entry_count, got.time_total);
         end
      endfunction

      function void check_response(rqd_rsp_type got);
         rqd_rsp_type want;
         if (owed.size() == 0) begin
            report("response with no request outstanding", '0, got);
            return;
         end
         want = owed.pop_front();
         if (got.found !== want.found || got.proc_id !== want.proc_id ||
             got.time_left !== want.time_left || got.overflow !== want.overflow ||
             got.entry_count !== want.entry_count || got.time_total !== want.time_total)
            report("response mismatch", want, got);
      endfunction

      function void flush_owed();
         while (owed.size() != 0)
            report("response never arrived", owed.pop_front(), '0);
      endfunction
   endclass

endpackage

// ===== verif/ready_queue_deque_with_time_sum_tb.sv =====
`timescale 1ns / 100ps

module ready_queue_deque_with_time_sum_tb;
   import rqd_pkg::*;
   import rqd_tb_pkg::*;

   localparam int RANDOM_REQUESTS = 750;

   // Receiver flow patterns, one per segment
   typedef enum int {FLOW_OPEN, FLOW_COIN, FLOW_THIRD, FLOW_BLOCK} flow_kind_type;
   // Sender request mixes, one per burst
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} req_mix_type;

   logic clock;
   logic reset;
   logic ready_q = 1'b0;

   rqd_req_if req_chan ();
   rqd_rsp_if rsp_chan ();

   ready_queue_shadow book;

   ready_queue_deque_with_time_sum uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   assign rsp_chan.ready = ready_q;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bail out if the run hangs; a correct run ends far earlier
   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: stall on a pattern that changes segment by segment
   int unsigned   seg_left = 0;
   int unsigned   beat     = 0;
   flow_kind_type seg_kind = FLOW_OPEN;

   always @(posedge clock) begin
      beat <= beat + 1;
      if (seg_left == 0) begin
         seg_kind <= flow_kind_type'($urandom_range(0, 3));
         seg_left <= $urandom_range(4, 48);
         ready_q  <= 1'b1;
      end else begin
         seg_left <= seg_left - 1;
         case (seg_kind)
            FLOW_OPEN:  ready_q <= 1'b1;
            FLOW_COIN:  ready_q <= 1'($urandom_range(0, 1));
            FLOW_THIRD: ready_q <= (beat % 3 == 0);
            // hold ready low for the last stretch of the segment
            default:    ready_q <= (seg_left > 20);
         endcase
      end
   end

   // Check every response the moment it is taken
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         book.check_response({rsp_chan.found, rsp_chan.out_proc_id, rsp_chan.out_time_left,
                              rsp_chan.overflow, rsp_chan.entry_count, rsp_chan.time_total});
   end

   // Offer one request and hold it until the block takes it
   task automatic offer_request(input logic [ACTION_W-1:0] action,
                                input logic [PID_W-1:0] pid,
                                input logic [TIME_W-1:0] tl);
      req_chan.valid     <= 1'b1;
      req_chan.action    <= action;
      req_chan.proc_id   <= pid;
      req_chan.time_left <= tl;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      book.note_request(action, pid, tl);
   endtask

   // Drop valid for a gap set by n (n is at least one)
   task automatic pause_sender(input int n);
      req_chan.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned             sent;
      int unsigned             burst;
      int unsigned             gap;
      int unsigned             roll;
      req_mix_type             mix;
      logic [ACTION_W-1:0]     action;
      logic [TIME_W-1:0]       tl;

      book = new();
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.action    <= ACT_QUERY;
      req_chan.proc_id   <= '0;
      req_chan.time_left <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: removals from an empty queue, then fill to the brim with the
      // largest times so the total peaks, push into a full queue, remove from
      // both ends and wrap the tail back below zero.
      offer_request(ACT_DEQ, 8'hFF, 16'hFFFF);
      offer_request(ACT_STEAL, 8'hFF, 16'hFFFF);
      offer_request(ACT_QUERY, 8'h00, 16'h0000);
      for (int i = 0; i < RING_DEPTH; i++)
         offer_request(ACT_ENQ, (i % 2 == 0) ? 8'hFF : PID_W'(i), 16'hFFFF);
      offer_request(ACT_ENQ, 8'hAA, 16'h5555);
      offer_request(ACT_QUERY, 8'h55, 16'hAAAA);
      offer_request(ACT_DEQ, 8'h00, 16'h0000);
      offer_request(ACT_STEAL, 8'h00, 16'h0000);
      offer_request(ACT_ENQ, 8'h00, 16'h0000);

      // Let the pipeline run dry once before the random part
      drain_responses();

      // Random: bursts lean toward filling or draining so both the full and the
      // empty corners are visited often; payloads on non-enqueue requests are
      // left random since the block must ignore them.
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 40);
         mix   = req_mix_type'($urandom_range(0, 2));
         for (int k = 0; k < burst; k++) begin
            roll = $urandom_range(0, 99);
            case (mix)
               MIX_FILL:  action = (roll < 65) ? ACT_ENQ : (roll < 80) ? ACT_DEQ :
                                   (roll < 92) ? ACT_STEAL : ACT_QUERY;
               MIX_DRAIN: action = (roll < 20) ? ACT_ENQ : (roll < 55) ? ACT_DEQ :
                                   (roll < 90) ? ACT_STEAL : ACT_QUERY;
               default:   action = (roll < 35) ? ACT_ENQ : (roll < 60) ? ACT_DEQ :
                                   (roll < 85) ? ACT_STEAL : ACT_QUERY;
            endcase
            case ($urandom_range(0, 7))
               0:       tl = '0;
               1:       tl = '1;
               default: tl = TIME_W'($urandom);
            endcase
            offer_request(action, PID_W'($urandom), tl);
            sent++;
         end
         // Mostly short gaps, sometimes none, now and then a full drain
         gap = $urandom_range(0, 12);
         if ($urandom_range(0, 9) == 0)
            drain_responses();
         else if (gap != 0 && gap <= 10)
            pause_sender(gap);
      end

      // Wait out the tail, then keep the clock running for stray responses
      drain_responses();
      repeat (20) @(posedge clock);
      book.flush_owed();

      if (book.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
